### hdl/pdce_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdce_pkg: shared types and constants of the chunk encoder
// Table geometry, form and payload codes, and the records passed between units.
// ---------------------------------------------------------------------------
package pdce_pkg;

	localparam int HASH_BITS   = 16;
	localparam int TABLE_DEPTH = 1 << HASH_BITS;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int QCNT_BITS   = 3;

	typedef enum logic [2:0] {
		FORM_PLAIN  = 3'd0,
		FORM_DICT_A = 3'd1,
		FORM_DICT_B = 3'd2,
		FORM_DICT_C = 3'd3,
		FORM_DICT_D = 3'd4,
		FORM_PRED_A = 3'd5,
		FORM_PRED_B = 3'd6,
		FORM_PRED_C = 3'd7
	} form_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_HASH = 2'd1,
		KIND_RAW  = 2'd2
	} kind_t;

	localparam form_t RESET_RANK_MAP [8] = '{
		FORM_PLAIN, FORM_DICT_A, FORM_DICT_B, FORM_PRED_A,
		FORM_PRED_B, FORM_DICT_C, FORM_PRED_C, FORM_DICT_D
	};

	// One request as it waits in the queue; the hash is already masked.
	typedef struct packed {
		logic [31:0]          data;
		logic [HASH_BITS-1:0] hash;
	} item_t;

	// A classified request handed to the ranking unit.
	typedef struct packed {
		logic                 valid;
		form_t                form;
		logic [31:0]          data;
		logic [HASH_BITS-1:0] hash;
	} sel_t;

endpackage

### hdl/predictive_dictionary_chunk_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// predictive_dictionary_chunk_encoder: predictive dictionary chunk encoder
// Classifies each 32-bit chunk against prediction and dictionary tables and
// emits the adaptive rank code of the chosen form with its payload.
// ---------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  in       | in_valid/in_stall  | data_word, word_hash
//  out      | out_valid/out_stall| form_id, code_bits, code_length,
//           |                    | payload_kind, payload
//
// One request per cycle is sustained while in_stall stays low; each request
// passes intake register, queue, table read, classify and result register.
// The table read-modify-write is the loop that sets the rate: the write of one
// request is forwarded to the request read just behind it.
// After reset both tables are swept to zero, one entry per cycle, across all
// 65536 entries; in_stall is high during the sweep.
// A stall on the output freezes the table stage; intake keeps filling the
// four-entry queue until it is full and only then raises in_stall.
//
module predictive_dictionary_chunk_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [15:0] word_hash,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  form_id,
	output logic [6:0]  code_bits,
	output logic [2:0]  code_length,
	output logic [1:0]  payload_kind,
	output logic [31:0] payload
);

	logic                            clr_busy;
	logic                            q_full, q_empty;
	logic [pdce_pkg::QCNT_BITS-1:0]  q_count;
	logic                            push, pop;
	pdce_pkg::item_t                 push_item, head;
	pdce_pkg::sel_t                  sel_s2;
	logic                            en;

	// The back end moves only while the result register is free or draining.
	assign en = !out_valid || !out_stall;

	pdce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_word (data_word),
		.word_hash (word_hash),
		.clr_busy  (clr_busy),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	pdce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty),
		.count     (q_count)
	);

	pdce_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.q_empty  (q_empty),
		.head     (head),
		.pop      (pop),
		.clr_busy (clr_busy),
		.sel_s2   (sel_s2)
	);

	pdce_rank u_rank (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.sel_s2       (sel_s2),
		.out_valid    (out_valid),
		.form_id      (form_id),
		.code_bits    (code_bits),
		.code_length  (code_length),
		.payload_kind (payload_kind),
		.payload      (payload)
	);

`ifndef ASSERT_OFF
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> in_stall)
		else $error("request accepted during table sweep");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= pdce_pkg::QCNT_BITS'(pdce_pkg::QUEUE_DEPTH) && !(pop && q_empty))
		else $error("queue overrun or underrun");

	a_plain_raw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && form_id == pdce_pkg::FORM_PLAIN |-> payload_kind == pdce_pkg::KIND_RAW)
		else $error("plain form without raw payload");

	// Ranks 6 and 7 both give a seven-bit code; only rank 7 has no marker bit.
	a_code_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(code_bits)
			&& ((code_length == 3'd7) == ((code_bits == '0) || code_bits[6])))
		else $error("malformed rank code");
`endif

endmodule

### hdl/pdce_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdce_front: request intake
// Registers each incoming request, masks its hash and pushes it into the queue.
// ---------------------------------------------------------------------------
module pdce_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [31:0]          data_word,
	input  logic [15:0]          word_hash,
	input  logic                 clr_busy,
	input  logic                 q_full,
	output logic                 push,
	output pdce_pkg::item_t      push_item
);

	logic            valid_q;
	pdce_pkg::item_t item_q;
	logic            accept;

	assign in_stall  = clr_busy || (valid_q && q_full);
	assign accept    = in_valid && !in_stall;
	assign push      = valid_q && !q_full;
	assign push_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.data <= data_word;
			item_q.hash <= word_hash[pdce_pkg::HASH_BITS-1:0];
		end
	end

endmodule

### hdl/pdce_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdce_queue: short request queue
// Decouples intake from the table stage so each side can stall on its own.
// ---------------------------------------------------------------------------
module pdce_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  pdce_pkg::item_t                   push_item,
	input  logic                              pop,
	output pdce_pkg::item_t                   head,
	output logic                              full,
	output logic                              empty,
	output logic [pdce_pkg::QCNT_BITS-1:0]    count
);

	pdce_pkg::item_t                  slot_q [pdce_pkg::QUEUE_DEPTH];
	logic [pdce_pkg::QPTR_BITS-1:0]   wr_ptr_q;
	logic [pdce_pkg::QPTR_BITS-1:0]   rd_ptr_q;
	logic [pdce_pkg::QCNT_BITS-1:0]   count_q;

	assign head  = slot_q[rd_ptr_q];
	assign full  = (count_q == pdce_pkg::QCNT_BITS'(pdce_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### hdl/pdce_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdce_back: table lookup and update
// Reads both tables, picks the form, shifts a table unless its first entry or
// a higher-priority one hit, and forwards the last write to the next request.
// ---------------------------------------------------------------------------
module pdce_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 q_empty,
	input  pdce_pkg::item_t      head,
	output logic                 pop,
	output logic                 clr_busy,
	output pdce_pkg::sel_t       sel_s2
);

	localparam int HB = pdce_pkg::HASH_BITS;

	logic [127:0] dict_mem [pdce_pkg::TABLE_DEPTH];
	logic [95:0]  pred_mem [pdce_pkg::TABLE_DEPTH];

	logic [HB:0]   clr_cnt_q;
	logic [HB-1:0] prev_hash_q;

	logic          valid_s1;
	logic [31:0]   data_s1;
	logic [HB-1:0] hash_s1;
	logic [HB-1:0] paddr_s1;
	logic [127:0]  dict_rd_s1;
	logic [95:0]   pred_rd_s1;

	logic            valid_s2;
	pdce_pkg::form_t form_s2;
	logic [31:0]     data_s2;
	logic [HB-1:0]   hash_s2;

	logic          dfwd_valid_q;
	logic [HB-1:0] dfwd_addr_q;
	logic [127:0]  dfwd_data_q;
	logic          pfwd_valid_q;
	logic [HB-1:0] pfwd_addr_q;
	logic [95:0]   pfwd_data_q;

	logic [127:0]  dict_cur;
	logic [95:0]   pred_cur;
	logic          hit_pa, hit_pb, hit_pc, hit_da, hit_db, hit_dc, hit_dd;
	logic          dict_we, pred_we;
	pdce_pkg::form_t form;

	assign clr_busy = !clr_cnt_q[HB];
	assign pop      = en && !q_empty && !clr_busy;
	assign sel_s2   = {valid_s2, form_s2, data_s2, hash_s2};

	always_comb begin
		dict_cur = (dfwd_valid_q && dfwd_addr_q == hash_s1) ? dfwd_data_q : dict_rd_s1;
		pred_cur = (pfwd_valid_q && pfwd_addr_q == paddr_s1) ? pfwd_data_q : pred_rd_s1;
		hit_pa = (pred_cur[31:0] == data_s1);
		hit_pb = (pred_cur[63:32] == data_s1);
		hit_pc = (pred_cur[95:64] == data_s1);
		hit_da = (dict_cur[31:0] == data_s1);
		hit_db = (dict_cur[63:32] == data_s1);
		hit_dc = (dict_cur[95:64] == data_s1);
		hit_dd = (dict_cur[127:96] == data_s1);
		if (hit_pa)      form = pdce_pkg::FORM_PRED_A;
		else if (hit_pb) form = pdce_pkg::FORM_PRED_B;
		else if (hit_pc) form = pdce_pkg::FORM_PRED_C;
		else if (hit_da) form = pdce_pkg::FORM_DICT_A;
		else if (hit_db) form = pdce_pkg::FORM_DICT_B;
		else if (hit_dc) form = pdce_pkg::FORM_DICT_C;
		else if (hit_dd) form = pdce_pkg::FORM_DICT_D;
		else             form = pdce_pkg::FORM_PLAIN;
		pred_we = en && valid_s1 && !hit_pa;
		dict_we = en && valid_s1 && !hit_pa && !hit_pb && !hit_pc && !hit_da;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q    <= '0;
			prev_hash_q  <= '0;
			valid_s1     <= 1'b0;
			dfwd_valid_q <= 1'b0;
			pfwd_valid_q <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (clr_busy) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (pop) begin
				prev_hash_q <= head.hash;
			end
			if (en) begin
				valid_s1 <= pop;
				valid_s2 <= valid_s1;
			end
			if (dict_we) begin
				dfwd_valid_q <= 1'b1;
			end
			if (pred_we) begin
				pfwd_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_s1  <= head.data;
			hash_s1  <= head.hash;
			paddr_s1 <= prev_hash_q;
		end
		if (dict_we) begin
			dfwd_addr_q <= hash_s1;
			dfwd_data_q <= {dict_cur[95:0], data_s1};
		end
		if (pred_we) begin
			pfwd_addr_q <= paddr_s1;
			pfwd_data_q <= {pred_cur[63:0], data_s1};
		end
		if (en && valid_s1) begin
			form_s2 <= form;
			data_s2 <= data_s1;
			hash_s2 <= hash_s1;
		end
	end

	// Dictionary store: one read port, one write port, cleared after reset.
	always_ff @(posedge clk) begin
		if (pop) begin
			dict_rd_s1 <= dict_mem[head.hash];
		end
		if (clr_busy) begin
			dict_mem[clr_cnt_q[HB-1:0]] <= '0;
		end else if (dict_we) begin
			dict_mem[hash_s1] <= {dict_cur[95:0], data_s1};
		end
	end

	// Prediction store, addressed by the previous request's hash.
	always_ff @(posedge clk) begin
		if (pop) begin
			pred_rd_s1 <= pred_mem[prev_hash_q];
		end
		if (clr_busy) begin
			pred_mem[clr_cnt_q[HB-1:0]] <= '0;
		end else if (pred_we) begin
			pred_mem[paddr_s1] <= {pred_cur[63:0], data_s1};
		end
	end

endmodule

### hdl/pdce_rank.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdce_rank: adaptive form ranking and result register
// Looks up the rank of the chosen form, emits its code and updates counters.
// ---------------------------------------------------------------------------
module pdce_rank (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  pdce_pkg::sel_t       sel_s2,
	output logic                 out_valid,
	output logic [2:0]           form_id,
	output logic [6:0]           code_bits,
	output logic [2:0]           code_length,
	output logic [1:0]           payload_kind,
	output logic [31:0]          payload
);

	pdce_pkg::form_t rank_map_q [8];
	logic [7:0]      usage_q [8];
	pdce_pkg::form_t rank_map_n [8];
	logic [7:0]      usage_n [8];

	logic [2:0]      rank;
	logic [2:0]      above_r;
	pdce_pkg::form_t above;
	logic [7:0]      cnt;
	logic            swap, halve;
	pdce_pkg::kind_t kind;
	logic [31:0]     pay;

	always_comb begin
		rank = '0;
		for (int r = 0; r < 8; r++) begin
			if (rank_map_q[3'(r)] == sel_s2.form) begin
				rank = 3'(r);
			end
		end
		cnt     = usage_q[sel_s2.form] + 8'd1;
		above_r = rank - 3'd1;
		above   = rank_map_q[above_r];
		swap    = (rank != '0) && (usage_q[above] < cnt);
		halve   = (rank == '0) && cnt[7];
		rank_map_n = rank_map_q;
		usage_n    = usage_q;
		usage_n[sel_s2.form] = cnt;
		if (swap) begin
			rank_map_n[above_r] = sel_s2.form;
			rank_map_n[rank]    = above;
		end
		if (halve) begin
			for (int r = 0; r < 8; r++) begin
				usage_n[3'(r)] = usage_n[3'(r)] >> 1;
			end
		end
		if (sel_s2.form == pdce_pkg::FORM_PLAIN) begin
			kind = pdce_pkg::KIND_RAW;
			pay  = sel_s2.data;
		end else if (sel_s2.form inside {[pdce_pkg::FORM_DICT_A:pdce_pkg::FORM_DICT_D]}) begin
			kind = pdce_pkg::KIND_HASH;
			pay  = 32'(sel_s2.hash);
		end else begin
			kind = pdce_pkg::KIND_NONE;
			pay  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid  <= 1'b0;
			rank_map_q <= pdce_pkg::RESET_RANK_MAP;
			for (int r = 0; r < 8; r++) begin
				usage_q[3'(r)] <= '0;
			end
		end else if (en) begin
			out_valid <= sel_s2.valid;
			if (sel_s2.valid) begin
				rank_map_q <= rank_map_n;
				usage_q    <= usage_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && sel_s2.valid) begin
			form_id      <= sel_s2.form;
			code_bits    <= (rank == 3'd7) ? 7'd0 : (7'd1 << rank);
			code_length  <= (rank == 3'd7) ? 3'd7 : (rank + 3'd1);
			payload_kind <= kind;
			payload      <= pay;
		end
	end

endmodule

### verif/predictive_dictionary_chunk_encoder_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// predictive_dictionary_chunk_encoder_checker: result predictor and comparator
// Watches both channels, predicts the coded result of each accepted request
// and compares every delivered result with the oldest prediction.
// ---------------------------------------------------------------------------
module predictive_dictionary_chunk_encoder_checker (
	input  logic        clk,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [15:0] word_hash,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  form_id,
	input  logic [6:0]  code_bits,
	input  logic [2:0]  code_length,
	input  logic [1:0]  payload_kind,
	input  logic [31:0] payload,
	output int          fail_count,
	output int          codes_waiting,
	output int          codes_checked
);

	typedef struct packed {
		pdce_pkg::form_t form;
		logic [6:0]      bits;
		logic [2:0]      len;
		pdce_pkg::kind_t kind;
		logic [31:0]     pay;
	} coded_t;

	bit [31:0] dict_words [pdce_pkg::TABLE_DEPTH][4];
	bit [31:0] pred_words [pdce_pkg::TABLE_DEPTH][3];
	bit [pdce_pkg::HASH_BITS-1:0] prior_hash;
	pdce_pkg::form_t rank_map [8];
	bit [7:0] usage [8];
	coded_t expected_codes [$];

	initial begin
		fail_count = 0;
		codes_checked = 0;
		codes_waiting = 0;
		prior_hash = '0;
		for (int r = 0; r < 8; r++) begin
			rank_map[3'(r)] = pdce_pkg::RESET_RANK_MAP[3'(r)];
			usage[3'(r)] = 8'd0;
		end
	end

	// Classifies one chunk, updates the tables and the ranking, and returns its code.
	function automatic coded_t encode_chunk(input logic [31:0] chunk, input logic [15:0] h_in);
		coded_t c;
		logic [pdce_pkg::HASH_BITS-1:0] h;
		pdce_pkg::form_t f;
		pdce_pkg::form_t above;
		int rank;
		logic [7:0] count;
		h = h_in[pdce_pkg::HASH_BITS-1:0];
		rank = 0;
		if (pred_words[prior_hash][0] == chunk) begin
			f = pdce_pkg::FORM_PRED_A;
		end else begin
			if (pred_words[prior_hash][1] == chunk) f = pdce_pkg::FORM_PRED_B;
			else if (pred_words[prior_hash][2] == chunk) f = pdce_pkg::FORM_PRED_C;
			else begin
				if (dict_words[h][0] == chunk) begin
					f = pdce_pkg::FORM_DICT_A;
				end else begin
					if (dict_words[h][1] == chunk) f = pdce_pkg::FORM_DICT_B;
					else if (dict_words[h][2] == chunk) f = pdce_pkg::FORM_DICT_C;
					else if (dict_words[h][3] == chunk) f = pdce_pkg::FORM_DICT_D;
					else f = pdce_pkg::FORM_PLAIN;
					dict_words[h][3] = dict_words[h][2];
					dict_words[h][2] = dict_words[h][1];
					dict_words[h][1] = dict_words[h][0];
					dict_words[h][0] = chunk;
				end
			end
			pred_words[prior_hash][2] = pred_words[prior_hash][1];
			pred_words[prior_hash][1] = pred_words[prior_hash][0];
			pred_words[prior_hash][0] = chunk;
		end
		prior_hash = h;
		c.form = f;
		if (f == pdce_pkg::FORM_PLAIN) begin
			c.kind = pdce_pkg::KIND_RAW;
			c.pay = chunk;
		end else if (f <= pdce_pkg::FORM_DICT_D) begin
			c.kind = pdce_pkg::KIND_HASH;
			c.pay = 32'(h);
		end else begin
			c.kind = pdce_pkg::KIND_NONE;
			c.pay = 32'd0;
		end
		for (int r = 0; r < 8; r++)
			if (rank_map[3'(r)] == f) rank = r;
		count = usage[f] + 8'd1;
		usage[f] = count;
		if (rank > 0) begin
			above = rank_map[3'(rank - 1)];
			if (usage[above] < count) begin
				rank_map[3'(rank - 1)] = f;
				rank_map[3'(rank)] = above;
			end
		end else if (count[7]) begin
			for (int r = 0; r < 8; r++) usage[3'(r)] = usage[3'(r)] >> 1;
		end
		c.bits = (rank < 7) ? 7'(1 << rank) : 7'd0;
		c.len = (rank < 7) ? 3'(rank + 1) : 3'd7;
		return c;
	endfunction

	always @(posedge clk) begin
		coded_t e;
		if (in_valid && !in_stall)
			expected_codes.push_back(encode_chunk(data_word, word_hash));
		if (out_valid && !out_stall) begin
			if (expected_codes.size() == 0) begin
				$display("%t: result with nothing expected (form %0d)", $time, form_id);
				fail_count++;
			end else begin
				e = expected_codes.pop_front();
				codes_checked++;
				if (form_id != e.form) begin
					$display("%t: form_id expected %0d actual %0d", $time, e.form, form_id);
					fail_count++;
				end
				if (code_bits != e.bits) begin
					$display("%t: code_bits expected %b actual %b", $time, e.bits, code_bits);
					fail_count++;
				end
				if (code_length != e.len) begin
					$display("%t: code_length expected %0d actual %0d", $time, e.len,
						code_length);
					fail_count++;
				end
				if (payload_kind != e.kind) begin
					$display("%t: payload_kind expected %0d actual %0d", $time, e.kind,
						payload_kind);
					fail_count++;
				end
				if (payload != e.pay) begin
					$display("%t: payload expected %h actual %h", $time, e.pay, payload);
					fail_count++;
				end
			end
		end
		codes_waiting = expected_codes.size();
	end

endmodule

### verif/predictive_dictionary_chunk_encoder_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// predictive_dictionary_chunk_encoder_test: top of the encoder testbench
// Drives directed and random chunk requests in bursts, stalls the output on a
// shifting pattern, and reports the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module predictive_dictionary_chunk_encoder_test;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_REQUESTS = 600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] data_word = 32'd0;
	logic [15:0] word_hash = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  form_id;
	logic [6:0]  code_bits;
	logic [2:0]  code_length;
	logic [1:0]  payload_kind;
	logic [31:0] payload;
	int          fail_count;
	int          codes_waiting;
	int          codes_checked;
	int          cycle_count = 0;
	int          requests_sent = 0;
	int          burst_left = 0;

	// A small set of recurring chunks, so that prediction and dictionary hits are common.
	logic [31:0] chunk_pool [8];

	predictive_dictionary_chunk_encoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_word(data_word), .word_hash(word_hash),
		.out_valid(out_valid), .out_stall(out_stall),
		.form_id(form_id), .code_bits(code_bits), .code_length(code_length),
		.payload_kind(payload_kind), .payload(payload)
	);

	predictive_dictionary_chunk_encoder_checker checker_inst (
		.clk(clk),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_word(data_word), .word_hash(word_hash),
		.out_valid(out_valid), .out_stall(out_stall),
		.form_id(form_id), .code_bits(code_bits), .code_length(code_length),
		.payload_kind(payload_kind), .payload(payload),
		.fail_count(fail_count), .codes_waiting(codes_waiting),
		.codes_checked(codes_checked)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// The cycle counter guards against a hung handshake, including the long table
	// sweep after reset.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("predictive_dictionary_chunk_encoder_test failed");
			$finish;
		end
	end

	// The receiver steps through four stall behaviors in turn: no stall at
	// all, light random stall, heavy random stall, or a fixed period.
	always @(posedge clk) begin
		int mode;
		mode = (cycle_count / 37) % 4;
		case (mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			2: begin
				out_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				out_stall <= (cycle_count % 5) < 2;
			end
		endcase
	end

	// A simple folding hash, so that one chunk mostly lands on one entry.
	function automatic logic [15:0] fold_hash(input logic [31:0] w);
		return w[31:16] ^ w[15:0] ^ {w[7:0], w[15:8]};
	endfunction

	// Presents one request and holds it until the encoder accepts it. Between
	// bursts the valid may drop for a random gap.
	task automatic send_chunk(input logic [31:0] w, input logic [15:0] h);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_word <= w;
		word_hash <= h;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
	endtask

	initial begin
		logic [31:0] w;
		int pick;
		for (int i = 0; i < 8; i++) chunk_pool[3'(i)] = $urandom;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A zero chunk under the cleared tables hits prediction a.
		send_chunk(32'h0000_0000, 16'h0000);
		send_chunk(32'hffff_ffff, 16'hffff);
		send_chunk(32'hffff_ffff, 16'hffff);
		send_chunk(32'h1234_5678, 16'hffff);
		// Rotating three chunks under one hash walks through prediction b and c.
		send_chunk(32'hA5A5_A5A5, 16'h0101);
		send_chunk(32'h5A5A_5A5A, 16'h0101);
		send_chunk(32'hA5A5_A5A5, 16'h0101);
		send_chunk(32'h5A5A_5A5A, 16'h0101);
		send_chunk(32'h1234_5678, 16'h0101);
		send_chunk(32'hA5A5_A5A5, 16'h0101);
		// The same hash reached from a fresh previous hash hits the dictionary.
		send_chunk(32'hDEAD_BEEF, 16'h0202);
		send_chunk(32'h5A5A_5A5A, 16'h0303);
		send_chunk(32'h0F0F_0F0F, 16'h0303);
		send_chunk(32'hDEAD_BEEF, 16'h0404);
		send_chunk(32'hA5A5_A5A5, 16'h0101);
		send_chunk(32'hDEAD_BEEF, 16'h0505);
		send_chunk(32'h1234_5678, 16'h0101);
		send_chunk(32'h8000_0001, 16'h8000);
		send_chunk(32'h7fff_fffe, 16'h7fff);
		send_chunk(32'h0000_0000, 16'h0000);

		// Random part: mostly recurring chunks with their folded hash, some fresh
		// chunks, and some noise with an unrelated hash.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				w = chunk_pool[3'($urandom_range(0, ((n / 100) % 2) ? 7 : 3))];
				send_chunk(w, fold_hash(w));
			end else if (pick < 9) begin
				w = $urandom;
				send_chunk(w, fold_hash(w));
			end else begin
				send_chunk($urandom, 16'($urandom));
			end
		end
		in_valid <= 1'b0;

		while (codes_waiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d chunk requests in random bursts against a shifting output stall;",
			requests_sent);
		$display("%0d coded results were checked field by field.", codes_checked);
		if (fail_count == 0) begin
			$display("predictive_dictionary_chunk_encoder_test passed");
		end else begin
			$display("predictive_dictionary_chunk_encoder_test failed");
		end
		$finish;
	end

endmodule
